// ===== rtl/seg_pkg.sv =====
`timescale 1ns / 1ps
package seg_pkg;

    localparam int N_ENTRIES  = 1024;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(N_ENTRIES);
    localparam int LEN_W      = IDX_W + 1;
    localparam int TREE_WORDS = 2 * N_ENTRIES;
    localparam int ADDR_W     = $clog2(TREE_WORDS);
    // node numbers run up to 2*N_ENTRIES (one past the last leaf)
    localparam int NODE_W     = ADDR_W + 1;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(N_ENTRIES);

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                         kind;
        logic [IDX_W-1:0]             index_low;
        logic [IDX_W-1:0]             index_high;
        logic signed [VALUE_BITS-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] range_sum;
        logic                         error;
    } t_out;

    // classified request handed from the front to the back
    typedef struct packed {
        logic                  kind;
        logic                  bad;
        logic [IDX_W-1:0]      index_low;
        logic [IDX_W-1:0]      index_high;
        logic [VALUE_BITS-1:0] value;
    } t_cmd;

endpackage

// ===== rtl/seg_ram.sv =====
`timescale 1ns / 1ps
module seg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/seg_front.sv =====
`timescale 1ns / 1ps
module seg_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  seg_pkg::t_in              i_item,
    input  logic                      i_cfg_we,
    input  logic [seg_pkg::LEN_W-1:0] i_cfg_data,
    input  logic                      i_busy,
    output logic                      o_cmd_valid,
    output seg_pkg::t_cmd             o_cmd,
    input  logic                      i_cmd_pop
);

    logic [seg_pkg::LEN_W-1:0] r_len;
    logic [seg_pkg::LEN_W-1:0] eff_len;
    seg_pkg::t_cmd             cmd_new;
    seg_pkg::t_cmd             r_q [2];
    logic                      r_wp;
    logic                      r_rp;
    logic [1:0]                r_cnt;
    logic                      accept;
    logic                      enq;
    logic                      lo_bad;

    // length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= seg_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_data;
        end
    end

    // classify the request
    always_comb begin
        eff_len = (r_len > seg_pkg::LEN_RESET) ? seg_pkg::LEN_RESET : r_len;
        lo_bad  = {1'b0, i_item.index_low} >= eff_len;
        cmd_new.kind       = i_item.kind;
        cmd_new.index_low  = i_item.index_low;
        cmd_new.index_high = i_item.index_high;
        cmd_new.value      = i_item.value;
        if (i_item.kind == seg_pkg::KIND_WRITE) begin
            cmd_new.bad = lo_bad;
        end else begin
            cmd_new.bad = (i_item.index_low > i_item.index_high) ||
                          ({1'b0, i_item.index_high} >= eff_len);
        end
    end

    assign o_full = (r_cnt == 2'd2) || i_busy;
    assign accept = i_push && !o_full;
    // a bad write changes nothing, so it never reaches the back
    assign enq    = accept && !(cmd_new.kind == seg_pkg::KIND_WRITE && cmd_new.bad);

    // two-entry request queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (enq) begin
                r_wp <= !r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(enq) - 2'(i_cmd_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wp] <= cmd_new;
        end
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

endmodule

// ===== rtl/seg_back.sv =====
`timescale 1ns / 1ps
module seg_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  seg_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_busy,
    output logic          o_res_valid,
    output seg_pkg::t_out o_res,
    input  logic          i_res_pop
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_WUP  = 3'd2;
    localparam logic [2:0] S_QRY  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic [seg_pkg::NODE_W-1:0] LEAF_BASE = seg_pkg::NODE_W'(seg_pkg::N_ENTRIES);
    localparam logic [seg_pkg::NODE_W-1:0] ROOT      = seg_pkg::NODE_W'(1);
    localparam logic [seg_pkg::ADDR_W-1:0] LAST_ADDR = seg_pkg::ADDR_W'(seg_pkg::TREE_WORDS - 1);

    logic [2:0]                      r_state, n_state;
    logic [seg_pkg::NODE_W-1:0]      r_node, n_node;
    logic [seg_pkg::NODE_W-1:0]      r_lr, n_lr;
    logic [seg_pkg::VALUE_BITS-1:0]  r_acc, n_acc;
    logic                            r_pend, n_pend;
    logic                            r_side, n_side;
    logic [seg_pkg::ADDR_W-1:0]      r_clr, n_clr;
    logic                            r_out_valid, n_out_valid;
    seg_pkg::t_out                   r_out, n_out;

    logic                            we;
    logic [seg_pkg::ADDR_W-1:0]      waddr;
    logic [seg_pkg::VALUE_BITS-1:0]  wdata;
    logic [seg_pkg::ADDR_W-1:0]      raddr;
    logic [seg_pkg::VALUE_BITS-1:0]  rdata;
    logic [seg_pkg::NODE_W-1:0]      parent;
    logic [seg_pkg::NODE_W-1:0]      leaf;
    logic [seg_pkg::NODE_W-1:0]      lr_dec;
    logic [seg_pkg::VALUE_BITS-1:0]  acc_in;

    seg_ram #(
        .WIDTH (seg_pkg::VALUE_BITS),
        .DEPTH (seg_pkg::TREE_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // walk controller
    always_comb begin
        n_state     = r_state;
        n_node      = r_node;
        n_lr        = r_lr;
        n_acc       = r_acc;
        n_pend      = 1'b0;
        n_side      = r_side;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !i_res_pop;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = r_clr;
        wdata       = '0;
        raddr       = '0;
        o_cmd_pop   = 1'b0;
        parent      = r_node >> 1;
        leaf        = LEAF_BASE + seg_pkg::NODE_W'(i_cmd.index_low);
        lr_dec      = r_lr;
        // sibling or range word read last cycle lands now
        acc_in      = r_pend ? (r_acc + rdata) : r_acc;

        case (r_state)
            S_CLR: begin
                we    = 1'b1;
                n_clr = r_clr + seg_pkg::ADDR_W'(1);
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == seg_pkg::KIND_WRITE) begin
                        o_cmd_pop = 1'b1;
                        we        = 1'b1;
                        waddr     = leaf[seg_pkg::ADDR_W-1:0];
                        wdata     = i_cmd.value;
                        raddr     = leaf[seg_pkg::ADDR_W-1:0] ^ seg_pkg::ADDR_W'(1);
                        n_acc     = i_cmd.value;
                        n_node    = leaf;
                        n_state   = S_WUP;
                    end else if (!r_out_valid) begin
                        o_cmd_pop = 1'b1;
                        if (i_cmd.bad) begin
                            n_out_valid     = 1'b1;
                            n_out.range_sum = '0;
                            n_out.error     = 1'b1;
                        end else begin
                            n_node  = leaf;
                            n_lr    = LEAF_BASE + seg_pkg::NODE_W'(i_cmd.index_high) +
                                      seg_pkg::NODE_W'(1);
                            n_acc   = '0;
                            n_side  = 1'b0;
                            n_state = S_QRY;
                        end
                    end
                end
            end
            S_WUP: begin
                // parent = written child + sibling just read
                we     = 1'b1;
                waddr  = parent[seg_pkg::ADDR_W-1:0];
                wdata  = r_acc + rdata;
                n_acc  = r_acc + rdata;
                n_node = parent;
                raddr  = parent[seg_pkg::ADDR_W-1:0] ^ seg_pkg::ADDR_W'(1);
                if (parent == ROOT) begin
                    n_state = S_IDLE;
                end
            end
            S_QRY: begin
                n_acc = acc_in;
                if (!r_side) begin
                    if (r_node >= r_lr) begin
                        n_state = S_FIN;
                    end else begin
                        if (r_node[0]) begin
                            raddr  = r_node[seg_pkg::ADDR_W-1:0];
                            n_pend = 1'b1;
                            n_node = r_node + seg_pkg::NODE_W'(1);
                        end
                        n_side = 1'b1;
                    end
                end else begin
                    if (r_lr[0]) begin
                        lr_dec = r_lr - seg_pkg::NODE_W'(1);
                        raddr  = lr_dec[seg_pkg::ADDR_W-1:0];
                        n_pend = 1'b1;
                    end
                    n_lr   = lr_dec >> 1;
                    n_node = r_node >> 1;
                    n_side = 1'b0;
                end
            end
            S_FIN: begin
                n_out_valid     = 1'b1;
                n_out.range_sum = r_acc;
                n_out.error     = 1'b0;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_side      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pend      <= n_pend;
            r_side      <= n_side;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_lr   <= n_lr;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

    assign o_busy      = (r_state == S_CLR);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ===== rtl/segment_tree_range_sum.sv =====
`timescale 1ns / 1ps
// Write request: the back end writes the leaf, then updates each of the 10 levels above it.
// Query request: at each tree level visited (up to 11) the left and then the right bound is
// checked, as the tree memory has a single read port; then a final check and the result.
// A bad query is answered from the idle state with an error result; a bad write is
// dropped in the front. Requests run one at a time; the front queue holds two more.
// Reset (synchronous, active low) clears the 2048-word tree in a pass; full stays high
// during the pass. Length resets to 1024.
module segment_tree_range_sum (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  seg_pkg::t_in              i_item,
    output logic                      empty,
    input  logic                      pop,
    output seg_pkg::t_out             o_result,
    input  logic                      i_cfg_we,
    input  logic [seg_pkg::LEN_W-1:0] i_cfg_data
);

    logic          busy;
    logic          cmd_valid;
    logic          cmd_pop;
    logic          res_valid;
    seg_pkg::t_cmd cmd;

    seg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_busy      (busy),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    seg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (o_result),
        .i_res_pop   (pop && !empty)
    );

    assign empty = !res_valid;

    // clearing pass starts right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("not blocked during tree clear");

    // an error result carries a zero sum
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.error) |-> (o_result.range_sum == '0))
        else $error("error result with nonzero sum");

    // back end takes requests only when one is queued
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("request queue underflow");

endmodule
